// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the drive command mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When cond holds at an edge, prop must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// When cond holds at an edge, prop must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/sdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcm_pkg
// Types and constants shared by the drive command mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sdcm_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;

	localparam int PAYLOAD_LEN   = 8;
	localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_LEN);
	localparam int PAYLOAD_CNT_W = $clog2(PAYLOAD_LEN + 1);

	localparam int PCT_LIMIT = 100;

	localparam int HALF_TRACK_W = 22;
	localparam int GAIN_W       = 24;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd1;

	localparam logic [HALF_TRACK_W-1:0] HALF_TRACK_RESET = 22'd23200;
	localparam logic [GAIN_W-1:0]       GAIN_RESET       = 24'd3302960;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HDR2 = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE = 3'd0,
		BK_CONV = 3'd1,
		BK_TURN = 3'd2,
		BK_DIFF = 3'd3,
		BK_MULA = 3'd4,
		BK_MULB = 3'd5,
		BK_SUM  = 3'd6,
		BK_OUT  = 3'd7
	} back_state_t;

	typedef struct packed {
		logic [31:0] v_bits;
		logic [31:0] w_bits;
	} job_t;

	typedef struct packed {
		logic signed [7:0] left_pct;
		logic signed [7:0] right_pct;
	} result_t;

	typedef struct packed {
		logic [HALF_TRACK_W-1:0] half_track;
		logic [GAIN_W-1:0]       gain;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/sdcm_queue.sv =====
// ----------------------------------------------------------------------------
// sdcm_queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sdcm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push & ~full;
	assign pop_ok  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= wdata;
		end
	end

	`ASSERT_NEXT(a_count_grows, clk, arst_n, push_ok && !pop_ok, count_q == $past(count_q) + CNT_W'(1), "queue count did not grow on a lone push")

endmodule

`default_nettype wire

// ===== sv/sdcm_front.sv =====
// ----------------------------------------------------------------------------
// sdcm_front
// Frame hunter: finds the header, gathers the payload, checks the sum.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sdcm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      rx_byte,
	output logic            full,
	output logic            job_push,
	output sdcm_pkg::job_t  job,
	input  logic            job_full
);

	sdcm_pkg::phase_t                    phase_q;
	sdcm_pkg::phase_t                    phase_d;
	logic [sdcm_pkg::PAYLOAD_CNT_W-1:0]  index_q;
	logic [sdcm_pkg::PAYLOAD_CNT_W-1:0]  index_d;
	logic [7:0]                          sum_q;
	logic [7:0]                          sum_d;
	logic [7:0]                          store_q [sdcm_pkg::PAYLOAD_LEN];
	logic                                store_we;
	logic                                accept;

	// A byte is held off whenever the job queue is full, whatever the frame state.
	assign full   = job_full;
	assign accept = push & ~job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdcm_pkg::PH_HUNT;
			index_q <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			index_q <= index_d;
			sum_q   <= sum_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		index_d  = index_q;
		sum_d    = sum_q;
		store_we = 1'b0;
		job_push = 1'b0;
		if (accept) begin
			unique case (phase_q)
				sdcm_pkg::PH_HDR2: begin
					if (rx_byte == sdcm_pkg::HDR_SECOND) begin
						phase_d = sdcm_pkg::PH_BODY;
						index_d = '0;
						sum_d   = '0;
					end else begin
						phase_d = sdcm_pkg::PH_HUNT;
					end
				end
				sdcm_pkg::PH_BODY: begin
					if (index_q < sdcm_pkg::PAYLOAD_CNT_W'(sdcm_pkg::PAYLOAD_LEN)) begin
						store_we = 1'b1;
						sum_d    = sum_q + rx_byte;
						index_d  = index_q + sdcm_pkg::PAYLOAD_CNT_W'(1);
					end else begin
						phase_d  = sdcm_pkg::PH_HUNT;
						index_d  = '0;
						job_push = (rx_byte == sum_q);
					end
				end
				default: begin
					phase_d = (rx_byte == sdcm_pkg::HDR_FIRST) ? sdcm_pkg::PH_HDR2
						: sdcm_pkg::PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[index_q[sdcm_pkg::PAYLOAD_IDX_W-1:0]] <= rx_byte;
		end
	end

	// Both singles are little endian.
	assign job.v_bits = {store_q[3], store_q[2], store_q[1], store_q[0]};
	assign job.w_bits = {store_q[7], store_q[6], store_q[5], store_q[4]};

	`ASSERT_IMPLY(a_push_at_sum, clk, arst_n, job_push, phase_q == sdcm_pkg::PH_BODY && index_q == sdcm_pkg::PAYLOAD_CNT_W'(sdcm_pkg::PAYLOAD_LEN), "frame queued outside the checksum byte")

endmodule

`default_nettype wire

// ===== sv/sdcm_back.sv =====
// ----------------------------------------------------------------------------
// sdcm_back
// Mixer sequencer: float conversion, turn product and gain scaling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sdcm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sdcm_pkg::cfg_t    cfg,
	input  logic              job_empty,
	input  sdcm_pkg::job_t    job,
	output logic              job_pop,
	input  logic              res_full,
	output logic              res_push,
	output sdcm_pkg::result_t res
);

	// Exponent at which the 24-bit mantissa lands unshifted in Q16.16.
	localparam logic [7:0] EXP_Q16 = 8'd134;
	localparam int TURN_W = 32 + sdcm_pkg::HALF_TRACK_W + 1;
	localparam int DIFF_W = TURN_W + 1;
	localparam int M_W    = DIFF_W - 1;
	localparam int LO_W   = 24;
	localparam int HI_W   = M_W - LO_W;
	localparam int PROD_W = HI_W + sdcm_pkg::GAIN_W;
	localparam int SUM_W  = PROD_W + 1;

	typedef struct packed {
		logic              nan;
		logic signed [31:0] val;
	} conv_t;

	function automatic conv_t to_q16(input logic [31:0] bits);
		conv_t       c;
		logic        neg;
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [23:0] mant;
		logic [7:0]  sh;
		logic [32:0] mag;
		logic [32:0] lim;
		neg  = bits[31];
		ex   = bits[30:23];
		fr   = bits[22:0];
		mant = {1'b1, fr};
		c.nan = 1'b0;
		if (ex == 8'hFF) begin
			c.nan = (fr != '0);
			mag   = 33'h1_0000_0000;
		end else if (ex == 8'h00) begin
			mag = '0;
		end else if (ex >= EXP_Q16) begin
			sh  = ex - EXP_Q16;
			mag = (sh >= 8'd8) ? 33'h1_0000_0000 : (33'(mant) << sh[2:0]);
		end else begin
			sh  = EXP_Q16 - ex;
			mag = (sh >= 8'd24) ? '0 : 33'(mant >> sh[4:0]);
		end
		lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		if (mag > lim) begin
			mag = lim;
		end
		c.val = c.nan ? '0 : (neg ? 32'(-mag) : mag[31:0]);
		return c;
	endfunction

	sdcm_pkg::back_state_t state_q;
	sdcm_pkg::back_state_t state_d;
	logic                  side_q;
	sdcm_pkg::job_t        job_q;
	logic signed [31:0]    v_q;
	logic signed [31:0]    w_q;
	logic signed [TURN_W-1:0] turn_q;
	logic [M_W-1:0]        m_l_q;
	logic [M_W-1:0]        m_r_q;
	logic                  neg_l_q;
	logic                  neg_r_q;
	logic [PROD_W-1:0]     prod_q;
	logic [PROD_W-1:0]     a_q;

	conv_t                 v_conv;
	conv_t                 w_conv;
	logic signed [TURN_W-1:0] turn_next;
	logic signed [DIFF_W-1:0] base_w;
	logic signed [DIFF_W-1:0] turn_w;
	logic signed [DIFF_W-1:0] diff_l;
	logic signed [DIFF_W-1:0] diff_r;
	logic [DIFF_W-1:0]     mag_l;
	logic [DIFF_W-1:0]     mag_r;
	logic [M_W-1:0]        m_sel;
	logic [HI_W-1:0]       mul_a;
	logic [PROD_W-1:0]     prod_next;
	logic [SUM_W-1:0]      sum;
	logic [31:0]           q;
	logic [7:0]            pct;
	logic signed [7:0]     pct_signed;
	logic                  neg_sel;

	assign v_conv = to_q16(job_q.v_bits);
	assign w_conv = to_q16(job_q.w_bits);

	assign turn_next = w_q * $signed({1'b0, cfg.half_track});

	assign base_w = {{(DIFF_W - 48){v_q[31]}}, v_q, 16'h0000};
	assign turn_w = {turn_q[TURN_W-1], turn_q};
	assign diff_l = base_w - turn_w;
	assign diff_r = base_w + turn_w;
	assign mag_l  = diff_l[DIFF_W-1] ? -diff_l : diff_l;
	assign mag_r  = diff_r[DIFF_W-1] ? -diff_r : diff_r;

	// One gain multiplier serves both halves of both sides.
	assign m_sel     = side_q ? m_r_q : m_l_q;
	assign neg_sel   = side_q ? neg_r_q : neg_l_q;
	assign mul_a     = (state_q == sdcm_pkg::BK_MULB) ? HI_W'(m_sel[LO_W-1:0])
		: m_sel[M_W-1:LO_W];
	assign prod_next = mul_a * cfg.gain;

	assign sum = SUM_W'(a_q) + SUM_W'(prod_q >> LO_W);
	assign q   = sum[SUM_W-1:LO_W];
	assign pct = (q > 32'(sdcm_pkg::PCT_LIMIT)) ? 8'(sdcm_pkg::PCT_LIMIT) : {1'b0, q[6:0]};
	assign pct_signed = neg_sel ? -$signed(pct) : $signed(pct);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdcm_pkg::BK_IDLE;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sdcm_pkg::BK_DIFF) begin
				side_q <= 1'b0;
			end else if (state_q == sdcm_pkg::BK_SUM) begin
				side_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			sdcm_pkg::BK_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = sdcm_pkg::BK_CONV;
				end
			end
			sdcm_pkg::BK_CONV: begin
				state_d = (v_conv.nan || w_conv.nan) ? sdcm_pkg::BK_OUT : sdcm_pkg::BK_TURN;
			end
			sdcm_pkg::BK_TURN: state_d = sdcm_pkg::BK_DIFF;
			sdcm_pkg::BK_DIFF: state_d = sdcm_pkg::BK_MULA;
			sdcm_pkg::BK_MULA: state_d = sdcm_pkg::BK_MULB;
			sdcm_pkg::BK_MULB: state_d = sdcm_pkg::BK_SUM;
			sdcm_pkg::BK_SUM: begin
				state_d = side_q ? sdcm_pkg::BK_OUT : sdcm_pkg::BK_MULA;
			end
			sdcm_pkg::BK_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = sdcm_pkg::BK_IDLE;
				end
			end
			default: state_d = sdcm_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sdcm_pkg::BK_IDLE: begin
				if (job_pop) begin
					job_q <= job;
				end
			end
			sdcm_pkg::BK_CONV: begin
				v_q <= v_conv.val;
				w_q <= w_conv.val;
				if (v_conv.nan || w_conv.nan) begin
					res <= '0;
				end
			end
			sdcm_pkg::BK_TURN: turn_q <= turn_next;
			sdcm_pkg::BK_DIFF: begin
				m_l_q   <= mag_l[M_W-1:0];
				m_r_q   <= mag_r[M_W-1:0];
				neg_l_q <= diff_l[DIFF_W-1];
				neg_r_q <= diff_r[DIFF_W-1];
			end
			sdcm_pkg::BK_MULA: prod_q <= prod_next;
			sdcm_pkg::BK_MULB: begin
				a_q    <= prod_q;
				prod_q <= prod_next;
			end
			sdcm_pkg::BK_SUM: begin
				if (side_q) begin
					res.right_pct <= pct_signed;
				end else begin
					res.left_pct <= pct_signed;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_NEXT(a_pop_starts_conv, clk, arst_n, job_pop, state_q == sdcm_pkg::BK_CONV, "job taken without starting conversion")
	`ASSERT_IMPLY(a_left_range, clk, arst_n, res_push, res.left_pct >= -8'sd100 && res.left_pct <= 8'sd100, "left command out of range")
	`ASSERT_IMPLY(a_right_range, clk, arst_n, res_push, res.right_pct >= -8'sd100 && res.right_pct <= 8'sd100, "right command out of range")

endmodule

`default_nettype wire

// ===== sv/serial_drive_command_mixer.sv =====
// ----------------------------------------------------------------------------
// serial_drive_command_mixer
// Serial frame decoder with differential-drive mixing of speed and turn rate.
// ----------------------------------------------------------------------------
// Push received serial bytes in; the block hunts for the header 0xAA 0x55,
// gathers eight payload bytes (linear speed and turn rate as little-endian
// IEEE singles) and a sum-of-bytes checksum, and for each frame with a good
// sum pops out one pair of wheel commands in percent, -100 to 100, both zero
// if either value is NaN. One byte transfer can happen every clock cycle; full
// rises only when two decoded frames are already waiting for the mixer. The
// mixer takes frames one at a time through float conversion, turn product,
// wheel differences and gain scaling, with the one shared gain multiplier used
// four times per frame (two partial products for each wheel). A frame is at
// least eleven bytes long, and the mixer keeps up with bytes arriving every
// cycle while results are popped. Results wait in a two-entry output queue, so
// the decoder and mixer keep working while a result sits unpopped. Configuration
// writes are always ready and should be made while no frame is in flight.
`default_nettype none

module serial_drive_command_mixer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic [7:0]                           rx_byte,
	output logic                                 full,
	input  logic                                 pop,
	output logic                                 empty,
	output logic signed [7:0]                    left_percent,
	output logic signed [7:0]                    right_percent,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sdcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sdcm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	sdcm_pkg::cfg_t    cfg_q;
	sdcm_pkg::job_t    front_job;
	sdcm_pkg::job_t    back_job;
	sdcm_pkg::result_t back_res;
	sdcm_pkg::result_t out_res;
	logic              job_push;
	logic              job_full;
	logic              job_pop;
	logic              job_empty;
	logic              res_push;
	logic              res_full;

	// Register writes never stall; an index past the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_track <= sdcm_pkg::HALF_TRACK_RESET;
			cfg_q.gain       <= sdcm_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sdcm_pkg::REG_HALF_TRACK: begin
					cfg_q.half_track <= cfg_data[sdcm_pkg::HALF_TRACK_W-1:0];
				end
				sdcm_pkg::REG_GAIN: cfg_q.gain <= cfg_data[sdcm_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front end takes each byte while the job queue has room and classifies it against the frame format.
	sdcm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.full     (full),
		.job_push (job_push),
		.job      (front_job),
		.job_full (job_full)
	);

	// Decoded frames wait here so the decoder stalls on the mixer only when this queue is full.
	sdcm_queue #(
		.WIDTH ($bits(sdcm_pkg::job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (front_job),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (back_job),
		.empty  (job_empty)
	);

	// The back end converts and mixes one frame at a time.
	sdcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (back_job),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// Finished commands are held here until the consumer pops them.
	sdcm_queue #(
		.WIDTH ($bits(sdcm_pkg::result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign left_percent  = out_res.left_pct;
	assign right_percent = out_res.right_pct;

endmodule

`default_nettype wire

// ===== verif/serial_drive_command_mixer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_drive_command_mixer_tb
// Self-checking bench for the serial frame decoder and wheel command mixer.
// ----------------------------------------------------------------------------
// Serial bytes are pushed in as whole frames, broken frames and noise. A
// byte-level model of the decoder and mixer runs on every accepted byte and
// queues the wheel commands that a good frame must produce. Every popped
// result is compared field by field with the oldest queued command. A short
// table of hand-picked frames comes first, then random traffic under several
// register settings, with random idle bursts on both sides, one long output
// stall that backs the block up, and a final stretch with no idling at all.
// ----------------------------------------------------------------------------

module serial_drive_command_mixer_tb;

	// Settle time after the last expected command, in cycles, before touching
	// the registers or ending the run.
	localparam int SETTLE_CYCLES  = 40;
	// Length of the forced output stall, in cycles.
	localparam int LONG_HOLD      = 400;
	// Cycles with no transfer of any kind before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 3000;

	// Register index past the last real register; writes to it are dropped.
	localparam logic [sdcm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum {
		FRM_GOOD,        // header, payload, correct checksum
		FRM_BAD_SUM,     // checksum off by a nonzero amount
		FRM_BROKEN_HDR,  // 0xAA 0xAA 0x55: the second 0xAA drops back to hunting
		FRM_STRAY_LEAD,  // 0x55 0xFF ahead of the header
		FRM_CUT          // header and a partial payload, nothing more
	} frame_kind_t;

	typedef struct {
		frame_kind_t       kind;
		logic [31:0]       v_bits;
		logic [31:0]       w_bits;
		bit                typed;  // the command below is the known answer
		sdcm_pkg::result_t cmd;
	} frame_row_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            push      = 1'b0;
	logic [7:0]                      rx_byte   = '0;
	logic                            full;
	logic                            pop       = 1'b0;
	logic                            empty;
	logic signed [7:0]               left_percent;
	logic signed [7:0]               right_percent;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [sdcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sdcm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	serial_drive_command_mixer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rx_byte      (rx_byte),
		.full         (full),
		.pop          (pop),
		.empty        (empty),
		.left_percent (left_percent),
		.right_percent(right_percent),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------
	// Byte-level model of the block: decoder state plus register copies.
	// ------------------------------------------------------------------
	sdcm_pkg::phase_t                  rx_phase   = sdcm_pkg::PH_HUNT;
	int                                body_count = 0;
	logic [7:0]                        body_bytes [sdcm_pkg::PAYLOAD_LEN];
	logic [7:0]                        body_sum   = '0;
	logic [sdcm_pkg::HALF_TRACK_W-1:0] track_q16  = sdcm_pkg::HALF_TRACK_RESET;
	logic [sdcm_pkg::GAIN_W-1:0]       gain_q16   = sdcm_pkg::GAIN_RESET;

	sdcm_pkg::result_t wheel_cmds_due [$];  // commands still to be popped, oldest first
	frame_row_t        pinned_q [$];        // directed frames that must produce a command
	int                error_count  = 0;
	int                bytes_sent   = 0;
	int                quiet_cycles = 0;

	// Flags for the byte sender and the result receiver; quiet_tail and hold_request are shared by both.
	bit tx_calm      = 1'b0;
	bit rx_calm      = 1'b0;
	bit quiet_tail   = 1'b0;
	bit hold_request = 1'b0;

	// IEEE single to saturating signed Q16.16, cutting the fraction toward zero.
	function automatic longint q16_from_single(input logic [31:0] bits, inout bit nan_seen);
		int          ex;
		logic [63:0] mant;
		logic [63:0] mag;
		logic [63:0] lim;
		ex = bits[30:23];
		mant = {40'd0, 1'b1, bits[22:0]};
		if (ex == 255) begin
			if (bits[22:0] != '0) begin
				nan_seen = 1'b1;
				return 0;
			end
			mag = 64'd1 << 32;
		end else if (ex == 0) begin
			mag = '0;
		end else if (ex >= 134) begin
			mag = (ex - 134 >= 8) ? (64'd1 << 32) : (mant << (ex - 134));
		end else begin
			mag = (134 - ex >= 24) ? 64'd0 : (mant >> (134 - ex));
		end
		lim = bits[31] ? (64'd1 << 31) : ((64'd1 << 31) - 1);
		if (mag > lim)
			mag = lim;
		return bits[31] ? -longint'(mag) : longint'(mag);
	endfunction

	// Q32.32 wheel speed times the gain, cut toward zero and clamped to 100.
	function automatic logic signed [7:0] wheel_percent(input longint speed);
		logic [63:0]       m;
		logic [63:0]       g;
		logic [63:0]       hi_part;
		logic [63:0]       lo_part;
		logic [63:0]       q;
		logic signed [7:0] pct;
		m = (speed < 0) ? -speed : speed;
		g = gain_q16;
		hi_part = (m >> 24) * g;
		lo_part = (m & 64'hFF_FFFF) * g;
		q = (hi_part + (lo_part >> 24)) >> 24;
		if (q > sdcm_pkg::PCT_LIMIT)
			q = sdcm_pkg::PCT_LIMIT;
		pct = q[7:0];
		return (speed < 0) ? -pct : pct;
	endfunction

	// Advances the decoder by one byte; returns 1 when a command comes out.
	function automatic bit frame_decode_step(input logic [7:0] b,
			output logic signed [7:0] left_pct, output logic signed [7:0] right_pct);
		bit     nan_seen;
		longint v;
		longint w;
		longint track;
		longint base;
		longint turn;
		left_pct = '0;
		right_pct = '0;
		nan_seen = 1'b0;
		case (rx_phase)
			sdcm_pkg::PH_HDR2: begin
				if (b == sdcm_pkg::HDR_SECOND) begin
					rx_phase = sdcm_pkg::PH_BODY;
					body_count = 0;
					body_sum = '0;
				end else begin
					rx_phase = sdcm_pkg::PH_HUNT;
				end
				return 1'b0;
			end
			sdcm_pkg::PH_BODY: begin
				if (body_count < sdcm_pkg::PAYLOAD_LEN) begin
					body_bytes[body_count] = b;
					body_sum += b;
					body_count++;
					return 1'b0;
				end
				rx_phase = sdcm_pkg::PH_HUNT;
				body_count = 0;
				if (b != body_sum)
					return 1'b0;
				v = q16_from_single({body_bytes[3], body_bytes[2], body_bytes[1],
						body_bytes[0]}, nan_seen);
				w = q16_from_single({body_bytes[7], body_bytes[6], body_bytes[5],
						body_bytes[4]}, nan_seen);
				// A NaN on either input zeroes both wheels.
				if (nan_seen)
					return 1'b1;
				track = track_q16;
				base = v * 65536;
				turn = w * track;
				left_pct = wheel_percent(base - turn);
				right_pct = wheel_percent(base + turn);
				return 1'b1;
			end
			default: begin
				// Hunting; the unused phase code would behave the same way.
				if (b == sdcm_pkg::HDR_FIRST)
					rx_phase = sdcm_pkg::PH_HDR2;
				else
					rx_phase = sdcm_pkg::PH_HUNT;
				return 1'b0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: register writes, byte transfers and result transfers,
	// all sampled at the rising edge before anything updates.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		logic signed [7:0] l_pred;
		logic signed [7:0] r_pred;
		sdcm_pkg::result_t due;
		frame_row_t        row;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sdcm_pkg::REG_HALF_TRACK:
						track_q16 = cfg_data[sdcm_pkg::HALF_TRACK_W-1:0];
					sdcm_pkg::REG_GAIN:
						gain_q16 = cfg_data[sdcm_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				if (frame_decode_step(rx_byte, l_pred, r_pred)) begin
					due = '{l_pred, r_pred};
					// Directed frames may carry the answer typed into the table.
					if (pinned_q.size() != 0) begin
						row = pinned_q.pop_front();
						if (row.typed)
							due = row.cmd;
					end
					wheel_cmds_due.push_back(due);
				end
			end
			if (pop && !empty) begin
				if (wheel_cmds_due.size() == 0) begin
					$error("unexpected result transfer: left_percent %0d, right_percent %0d",
							left_percent, right_percent);
					error_count++;
				end else begin
					due = wheel_cmds_due.pop_front();
					if (left_percent !== due.left_pct) begin
						$error("left_percent: expected %0d, got %0d", due.left_pct, left_percent);
						error_count++;
					end
					if (right_percent !== due.right_pct) begin
						$error("right_percent: expected %0d, got %0d", due.right_pct,
								right_percent);
						error_count++;
					end
				end
			end
		end
	end

	// Ends the run if nothing at all moves for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side: pops with random idle bursts, calm stretches, and one
	// long stall on request from the sender.
	// ------------------------------------------------------------------
	initial begin : receiver
		int held;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				pop <= 1'b0;
				held = 0;
				while (held < LONG_HOLD) begin
					@(posedge clk);
					held++;
				end
				hold_request = 1'b0;
			end else if (!quiet_tail && !rx_calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
		end
	end

	// ------------------------------------------------------------------
	// Byte side.
	// ------------------------------------------------------------------

	// One byte transfer, then maybe an idle burst. Push stays high between
	// back-to-back bytes.
	task automatic put_byte(input logic [7:0] b);
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
		if (!tx_calm && !quiet_tail && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_frame(input frame_kind_t kind, input logic [31:0] v,
			input logic [31:0] w);
		logic [7:0] body [sdcm_pkg::PAYLOAD_LEN];
		logic [7:0] sum;
		int         cut;
		body = '{v[7:0], v[15:8], v[23:16], v[31:24], w[7:0], w[15:8], w[23:16], w[31:24]};
		sum = '0;
		foreach (body[i])
			sum += body[i];
		cut = (kind == FRM_CUT) ? $urandom_range(0, sdcm_pkg::PAYLOAD_LEN - 1)
			: sdcm_pkg::PAYLOAD_LEN;
		if (kind == FRM_STRAY_LEAD) begin
			put_byte(sdcm_pkg::HDR_SECOND);
			put_byte(8'hFF);
		end
		put_byte(sdcm_pkg::HDR_FIRST);
		if (kind == FRM_BROKEN_HDR)
			put_byte(sdcm_pkg::HDR_FIRST);
		put_byte(sdcm_pkg::HDR_SECOND);
		for (int i = 0; i < cut; i++)
			put_byte(body[i]);
		if (kind == FRM_CUT)
			return;
		put_byte((kind == FRM_BAD_SUM) ? sum + 8'($urandom_range(1, 255)) : sum);
	endtask

	// Mostly plausible speeds around one m/s, with a share of raw patterns,
	// infinities, NaNs, zeros and subnormals.
	function automatic logic [31:0] random_single();
		logic [31:0] bits;
		bits = $urandom();
		case ($urandom_range(0, 11))
			0:       ;
			1:       bits[30:23] = 8'hFF;
			2:       bits[30:0] = {8'hFF, 23'd0};
			3:       bits[30:23] = 8'h00;
			4:       bits[30:0] = '0;
			5:       bits[30:23] = 8'($urandom_range(112, 142));
			default: bits[30:23] = 8'($urandom_range(118, 131));
		endcase
		return bits;
	endfunction

	task automatic run_frames(input int byte_budget);
		int stop_at;
		int pick;
		stop_at = bytes_sent + byte_budget;
		while (bytes_sent < stop_at) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_frame(FRM_GOOD, random_single(), random_single());
			else if (pick < 78)
				send_frame(FRM_BAD_SUM, random_single(), random_single());
			else if (pick < 83)
				send_frame(FRM_BROKEN_HDR, random_single(), random_single());
			else if (pick < 88)
				send_frame(FRM_CUT, random_single(), random_single());
			else if (pick < 92)
				send_frame(FRM_STRAY_LEAD, random_single(), random_single());
			else
				repeat ($urandom_range(1, 6))
					put_byte(($urandom_range(0, 4) == 0) ? sdcm_pkg::HDR_FIRST
						: 8'($urandom()));
		end
		tx_calm = 1'b0;
	endtask

	// Stop sending, wait for every expected command, then let the mixer settle.
	task automatic drain_results();
		push <= 1'b0;
		do
			@(posedge clk);
		while (wheel_cmds_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sdcm_pkg::CFG_IDX_W-1:0] idx,
			input logic [sdcm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Register writes only ever happen with the block drained.
	task automatic reconfigure(input logic [sdcm_pkg::CFG_DATA_W-1:0] track_word,
			input logic [sdcm_pkg::CFG_DATA_W-1:0] gain_word, input bit poke_spare);
		drain_results();
		write_reg(sdcm_pkg::REG_HALF_TRACK, track_word);
		write_reg(sdcm_pkg::REG_GAIN, gain_word);
		if (poke_spare)
			write_reg(REG_SPARE, sdcm_pkg::CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// Hand-picked frames under the reset gain of about 50.4 percent per m/s.
	frame_row_t directed_rows [16] = '{
		'{FRM_GOOD,       32'h0000_0000, 32'h0000_0000, 1'b1, '{8'sd0,    8'sd0}},
		'{FRM_GOOD,       32'h3F80_0000, 32'h0000_0000, 1'b1, '{8'sd50,   8'sd50}},
		'{FRM_GOOD,       32'hBF80_0000, 32'h0000_0000, 1'b1, '{-8'sd50,  -8'sd50}},
		'{FRM_GOOD,       32'h7F80_0000, 32'h0000_0000, 1'b1, '{8'sd100,  8'sd100}},
		'{FRM_GOOD,       32'hFF80_0000, 32'h0000_0000, 1'b1, '{-8'sd100, -8'sd100}},
		'{FRM_GOOD,       32'h4700_0000, 32'h0000_0000, 1'b1, '{8'sd100,  8'sd100}},
		'{FRM_GOOD,       32'hC700_0000, 32'h8000_0000, 1'b1, '{-8'sd100, -8'sd100}},
		'{FRM_GOOD,       32'h7FC0_0000, 32'h3F80_0000, 1'b1, '{8'sd0,    8'sd0}},
		'{FRM_GOOD,       32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{8'sd0,    8'sd0}},
		'{FRM_GOOD,       32'h0000_0001, 32'h8000_0000, 1'b1, '{8'sd0,    8'sd0}},
		'{FRM_BAD_SUM,    32'h3F80_0000, 32'h0000_0000, 1'b0, '{8'sd0,    8'sd0}},
		'{FRM_BROKEN_HDR, 32'h3F80_0000, 32'h0000_0000, 1'b0, '{8'sd0,    8'sd0}},
		'{FRM_STRAY_LEAD, 32'h3F00_0000, 32'h3F00_0000, 1'b0, '{8'sd0,    8'sd0}},
		'{FRM_GOOD,       32'h0000_0000, 32'h3F80_0000, 1'b0, '{8'sd0,    8'sd0}},
		'{FRM_GOOD,       32'h3780_0000, 32'h0000_0000, 1'b0, '{8'sd0,    8'sd0}},
		'{FRM_GOOD,       32'h4000_0000, 32'hC040_0000, 1'b0, '{8'sd0,    8'sd0}}
	};

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Only complete frames with a good sum leave a command behind, so only
		// those rows queue an entry for the scoreboard.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == FRM_GOOD || directed_rows[i].kind == FRM_STRAY_LEAD)
				pinned_q.push_back(directed_rows[i]);
			send_frame(directed_rows[i].kind, directed_rows[i].v_bits, directed_rows[i].w_bits);
		end

		run_frames(120);

		// Widest track and gain; the track write also carries bits above its width.
		reconfigure(24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
		run_frames(250);

		// Zero track and zero gain, plus a write to an index that does not exist.
		reconfigure(24'h00_0000, 24'h00_0000, 1'b1);
		run_frames(200);

		// Gain of one percent per m/s keeps most commands well inside the clamp.
		reconfigure(sdcm_pkg::CFG_DATA_W'($urandom()), 24'h01_0000, 1'b0);
		run_frames(250);

		// Back the block up: the receiver stalls while full frames keep coming,
		// so the output queue and the job buffer fill and the input stalls.
		reconfigure(sdcm_pkg::CFG_DATA_W'($urandom()),
				sdcm_pkg::CFG_DATA_W'($urandom_range(24'h10_0000, 24'hFF_FFFF)), 1'b1);
		tx_calm = 1'b1;
		hold_request = 1'b1;
		repeat (40)
			send_frame(FRM_GOOD, random_single(), random_single());
		tx_calm = 1'b0;

		// Closing stretch at full rate on both sides under the reset settings.
		reconfigure(sdcm_pkg::CFG_DATA_W'(sdcm_pkg::HALF_TRACK_RESET),
				sdcm_pkg::CFG_DATA_W'(sdcm_pkg::GAIN_RESET), 1'b0);
		quiet_tail = 1'b1;
		run_frames(160);

		drain_results();
		if (error_count == 0 && wheel_cmds_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
